FILE: design/x86enc_pkg.sv
package x86enc_pkg;

    // operation codes of the input transaction
    localparam logic [3:0] OP_MOV = 4'd0;
    localparam logic [3:0] OP_ADD = 4'd1;
    localparam logic [3:0] OP_OR  = 4'd2;
    localparam logic [3:0] OP_AND = 4'd3;
    localparam logic [3:0] OP_SUB = 4'd4;
    localparam logic [3:0] OP_XOR = 4'd5;
    localparam logic [3:0] OP_INT = 4'd6;
    localparam logic [3:0] OP_HLT = 4'd7;
    localparam logic [3:0] OP_CLC = 4'd8;
    localparam logic [3:0] OP_CMC = 4'd9;
    localparam logic [3:0] OP_CLI = 4'd10;
    localparam logic [3:0] OP_CLD = 4'd11;
    localparam logic [3:0] OP_NOP = 4'd12;

    // operand size codes
    localparam logic [1:0] SZ_NONE  = 2'd0;
    localparam logic [1:0] SZ_BYTE  = 2'd1;
    localparam logic [1:0] SZ_WORD  = 2'd2;
    localparam logic [1:0] SZ_DWORD = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_REG  = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    // register number of the accumulator (al, ax, eax)
    localparam logic [2:0] REG_ACC = 3'd0;

    localparam int MAX_BYTES = 6;

    localparam logic [7:0] BYTE_MOV_IMM8  = 8'hb0;
    localparam logic [7:0] BYTE_MOV_RM    = 8'h88;
    localparam logic [7:0] BYTE_OPSIZE    = 8'h66;
    localparam logic [7:0] BYTE_MOV_IMM   = 8'hb8;
    localparam logic [7:0] BYTE_GRP1_IB   = 8'h80;
    localparam logic [7:0] BYTE_GRP1_SIB  = 8'h83;
    localparam logic [7:0] BYTE_GRP1_IZ   = 8'h81;
    localparam logic [7:0] BYTE_MODRM_REG = 8'hc0;
    localparam logic [7:0] BYTE_INT       = 8'hcd;
    localparam logic [7:0] BYTE_HLT       = 8'hf4;
    localparam logic [7:0] BYTE_CLC       = 8'hf8;
    localparam logic [7:0] BYTE_CMC       = 8'hf5;
    localparam logic [7:0] BYTE_CLI       = 8'hfa;
    localparam logic [7:0] BYTE_CLD       = 8'hfc;
    localparam logic [7:0] BYTE_NOP       = 8'h90;
    localparam logic [7:0] BYTE_BAD       = 8'hff;

    // ALU group opcode bases and ModRM /digit values
    localparam logic [7:0] BASE_ADD = 8'h00;
    localparam logic [7:0] BASE_OR  = 8'h08;
    localparam logic [7:0] BASE_AND = 8'h20;
    localparam logic [7:0] BASE_SUB = 8'h28;
    localparam logic [7:0] BASE_XOR = 8'h30;

    localparam logic [2:0] DIGIT_ADD = 3'd0;
    localparam logic [2:0] DIGIT_OR  = 3'd1;
    localparam logic [2:0] DIGIT_AND = 3'd4;
    localparam logic [2:0] DIGIT_SUB = 3'd5;
    localparam logic [2:0] DIGIT_XOR = 3'd6;

    typedef struct packed {
        logic [3:0]  op;
        logic [1:0]  dest_size;
        logic [2:0]  dest_reg;
        logic [1:0]  src_size;
        logic [2:0]  src_reg;
        logic [31:0] immediate;
    } item_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
        logic [1:0] status;
    } code_t;

    // encoded instruction: byte 0 goes out first
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
        logic [1:0]                status;
    } enc_t;

endpackage

FILE: design/x86enc_encoder.sv
module x86enc_encoder
(
    input  x86enc_pkg::item_t item,
    output x86enc_pkg::enc_t  enc
);

    logic [7:0] base;
    logic [2:0] digit;
    logic [7:0] modrm_digit;
    logic [7:0] modrm_src;
    logic [7:0] one_byte;
    logic [2:0] width;
    logic [2:0] n;

    // opcode base of the ALU group
    always_comb
    begin
        case (item.op)
            x86enc_pkg::OP_MOV: base = x86enc_pkg::BYTE_MOV_RM;
            x86enc_pkg::OP_ADD: base = x86enc_pkg::BASE_ADD;
            x86enc_pkg::OP_OR:  base = x86enc_pkg::BASE_OR;
            x86enc_pkg::OP_AND: base = x86enc_pkg::BASE_AND;
            x86enc_pkg::OP_SUB: base = x86enc_pkg::BASE_SUB;
            x86enc_pkg::OP_XOR: base = x86enc_pkg::BASE_XOR;
            default:            base = x86enc_pkg::BASE_ADD;
        endcase
    end

    // ModRM /digit of the ALU group
    always_comb
    begin
        case (item.op)
            x86enc_pkg::OP_OR:  digit = x86enc_pkg::DIGIT_OR;
            x86enc_pkg::OP_AND: digit = x86enc_pkg::DIGIT_AND;
            x86enc_pkg::OP_SUB: digit = x86enc_pkg::DIGIT_SUB;
            x86enc_pkg::OP_XOR: digit = x86enc_pkg::DIGIT_XOR;
            default:            digit = x86enc_pkg::DIGIT_ADD;
        endcase
    end

    // one-byte instructions; anything unknown encodes as the bad byte
    always_comb
    begin
        case (item.op)
            x86enc_pkg::OP_HLT: one_byte = x86enc_pkg::BYTE_HLT;
            x86enc_pkg::OP_CLC: one_byte = x86enc_pkg::BYTE_CLC;
            x86enc_pkg::OP_CMC: one_byte = x86enc_pkg::BYTE_CMC;
            x86enc_pkg::OP_CLI: one_byte = x86enc_pkg::BYTE_CLI;
            x86enc_pkg::OP_CLD: one_byte = x86enc_pkg::BYTE_CLD;
            x86enc_pkg::OP_NOP: one_byte = x86enc_pkg::BYTE_NOP;
            default:            one_byte = x86enc_pkg::BYTE_BAD;
        endcase
    end

    assign modrm_digit = {2'b11, digit, item.dest_reg};
    assign modrm_src   = {2'b11, item.src_reg, item.dest_reg};

    always_comb
    begin
        case (item.dest_size)
            x86enc_pkg::SZ_BYTE: width = 3'd1;
            x86enc_pkg::SZ_WORD: width = 3'd2;
            default:             width = 3'd4;
        endcase
    end

    always_comb
    begin
        enc.bytes  = '0;
        enc.status = x86enc_pkg::ST_OK;
        n          = 3'd0;
        case (item.op)
            x86enc_pkg::OP_MOV, x86enc_pkg::OP_ADD, x86enc_pkg::OP_OR,
            x86enc_pkg::OP_AND, x86enc_pkg::OP_SUB, x86enc_pkg::OP_XOR:
            begin
                if (item.dest_size == x86enc_pkg::SZ_NONE)
                begin
                    enc.bytes[0] = x86enc_pkg::BYTE_BAD;
                    enc.status   = x86enc_pkg::ST_NOT_REG;
                    n            = 3'd1;
                end
                else if (item.src_size != x86enc_pkg::SZ_NONE
                         && item.src_size != item.dest_size)
                begin
                    enc.bytes[0] = x86enc_pkg::BYTE_BAD;
                    enc.status   = x86enc_pkg::ST_MISMATCH;
                    n            = 3'd1;
                end
                else
                begin
                    if (item.dest_size == x86enc_pkg::SZ_WORD)
                    begin
                        enc.bytes[n] = x86enc_pkg::BYTE_OPSIZE;
                        n = n + 3'd1;
                    end
                    if (item.src_size != x86enc_pkg::SZ_NONE)
                    begin
                        enc.bytes[n] = (item.dest_size == x86enc_pkg::SZ_BYTE)
                                       ? base : base + 8'd1;
                        n = n + 3'd1;
                        enc.bytes[n] = modrm_src;
                        n = n + 3'd1;
                    end
                    else if (item.op == x86enc_pkg::OP_MOV)
                    begin
                        enc.bytes[n] = ((item.dest_size == x86enc_pkg::SZ_BYTE)
                                        ? x86enc_pkg::BYTE_MOV_IMM8
                                        : x86enc_pkg::BYTE_MOV_IMM)
                                       | {5'd0, item.dest_reg};
                        n = n + 3'd1;
                        for (int i = 0; i < 4; i++)
                        begin
                            if (3'(i) < width)
                            begin
                                enc.bytes[n] = item.immediate[8*i +: 8];
                                n = n + 3'd1;
                            end
                        end
                    end
                    else if (item.dest_size == x86enc_pkg::SZ_BYTE)
                    begin
                        if (item.dest_reg == x86enc_pkg::REG_ACC)
                        begin
                            enc.bytes[n] = base + 8'd4;
                            n = n + 3'd1;
                        end
                        else
                        begin
                            enc.bytes[n] = x86enc_pkg::BYTE_GRP1_IB;
                            n = n + 3'd1;
                            enc.bytes[n] = modrm_digit;
                            n = n + 3'd1;
                        end
                        enc.bytes[n] = item.immediate[7:0];
                        n = n + 3'd1;
                    end
                    else if (item.immediate < 32'd128)
                    begin
                        // sign-extended imm8 short form
                        enc.bytes[n] = x86enc_pkg::BYTE_GRP1_SIB;
                        n = n + 3'd1;
                        enc.bytes[n] = modrm_digit;
                        n = n + 3'd1;
                        enc.bytes[n] = item.immediate[7:0];
                        n = n + 3'd1;
                    end
                    else
                    begin
                        if (item.dest_reg == x86enc_pkg::REG_ACC)
                        begin
                            enc.bytes[n] = base + 8'd5;
                            n = n + 3'd1;
                        end
                        else
                        begin
                            enc.bytes[n] = x86enc_pkg::BYTE_GRP1_IZ;
                            n = n + 3'd1;
                            enc.bytes[n] = modrm_digit;
                            n = n + 3'd1;
                        end
                        for (int i = 0; i < 4; i++)
                        begin
                            if (3'(i) < width)
                            begin
                                enc.bytes[n] = item.immediate[8*i +: 8];
                                n = n + 3'd1;
                            end
                        end
                    end
                end
            end
            x86enc_pkg::OP_INT:
            begin
                enc.bytes[0] = x86enc_pkg::BYTE_INT;
                enc.bytes[1] = item.immediate[7:0];
                n            = 3'd2;
            end
            default:
            begin
                enc.bytes[0] = one_byte;
                n            = 3'd1;
            end
        endcase
        enc.count = n;
    end

endmodule

FILE: design/x86_instruction_encoder.sv
// Path: an accepted transaction is registered in the input register, encoded combinationally
// and loaded into the byte serializer when it is empty or the previous final byte leaves.
// Output: the byte-wide result channel carries each instruction's 1 to 6 bytes in order;
// the next instruction waits in the input register meanwhile.
// Reset: rst_n clears both valid flags at once; payload registers keep no reset.
module x86_instruction_encoder
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  x86enc_pkg::item_t item,
    output logic              code_valid,
    input  logic              code_stall,
    output x86enc_pkg::code_t code
);

    // input register: holds one instruction while the previous one drains
    logic              in_valid_reg;
    x86enc_pkg::item_t in_item_reg;

    // byte serializer: the low byte of bytes_reg is the result on the port
    logic                                  ser_valid_reg;
    logic                                  ser_valid_next;
    logic [x86enc_pkg::MAX_BYTES-1:0][7:0] bytes_reg;
    logic [x86enc_pkg::MAX_BYTES-1:0][7:0] bytes_next;
    logic [2:0]                            left_reg;
    logic [2:0]                            left_next;
    logic [1:0]                            status_reg;
    logic [1:0]                            status_next;

    x86enc_pkg::enc_t enc;

    logic take;
    logic last;
    logic load;

    x86enc_encoder u_encoder
    (
        .item (in_item_reg),
        .enc  (enc)
    );

    assign last = (left_reg == 3'd1);
    assign take = ser_valid_reg && !code_stall;

    // move the held instruction into the serializer when it is empty or
    // its final byte leaves in this cycle
    assign load = in_valid_reg && (!ser_valid_reg || (take && last));

    // the input register is free when empty or when it hands off this cycle
    assign item_stall = in_valid_reg && !load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_item_reg <= item;
        end
    end

    always_comb
    begin
        ser_valid_next = ser_valid_reg;
        bytes_next     = bytes_reg;
        left_next      = left_reg;
        status_next    = status_reg;
        if (load)
        begin
            ser_valid_next = 1'b1;
            bytes_next     = enc.bytes;
            left_next      = enc.count;
            status_next    = enc.status;
        end
        else if (take)
        begin
            // advance to the next byte, or drop the finished instruction
            ser_valid_next = !last;
            bytes_next     = bytes_reg >> 8;
            left_next      = left_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
        end
        else
        begin
            ser_valid_reg <= ser_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg  <= bytes_next;
        left_reg   <= left_next;
        status_reg <= status_next;
    end

    assign code_valid     = ser_valid_reg;
    assign code.code_byte = bytes_reg[0];
    assign code.last_byte = last;
    assign code.status    = status_reg;

endmodule

FILE: verif/encoding_checker.sv
`timescale 1ns / 100ps

module encoding_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  x86enc_pkg::item_t item,
    input  logic              code_valid,
    input  logic              code_stall,
    input  x86enc_pkg::code_t code,
    output int                mismatch_count,
    output int                outstanding
);

    x86enc_pkg::code_t expected_bytes [$];

    // Append the machine-code bytes of one instruction to the expected stream.
    function automatic void predict_encoding(input x86enc_pkg::item_t it);
        logic [7:0]        enc [$];
        logic [7:0]        base;
        logic [2:0]        digit;
        logic [7:0]        modrm_digit;
        logic [7:0]        one_byte;
        logic [1:0]        st;
        x86enc_pkg::code_t entry;
        int                width;
        int                imm_len;

        st      = x86enc_pkg::ST_OK;
        imm_len = 0;
        if (it.op <= x86enc_pkg::OP_XOR)
        begin
            case (it.op)
                x86enc_pkg::OP_ADD: base = x86enc_pkg::BASE_ADD;
                x86enc_pkg::OP_OR:  base = x86enc_pkg::BASE_OR;
                x86enc_pkg::OP_AND: base = x86enc_pkg::BASE_AND;
                x86enc_pkg::OP_SUB: base = x86enc_pkg::BASE_SUB;
                x86enc_pkg::OP_XOR: base = x86enc_pkg::BASE_XOR;
                default:            base = x86enc_pkg::BYTE_MOV_RM;
            endcase
            case (it.op)
                x86enc_pkg::OP_OR:  digit = x86enc_pkg::DIGIT_OR;
                x86enc_pkg::OP_AND: digit = x86enc_pkg::DIGIT_AND;
                x86enc_pkg::OP_SUB: digit = x86enc_pkg::DIGIT_SUB;
                x86enc_pkg::OP_XOR: digit = x86enc_pkg::DIGIT_XOR;
                default:            digit = x86enc_pkg::DIGIT_ADD;
            endcase
            modrm_digit = x86enc_pkg::BYTE_MODRM_REG | {2'b00, digit, it.dest_reg};
            case (it.dest_size)
                x86enc_pkg::SZ_BYTE: width = 1;
                x86enc_pkg::SZ_WORD: width = 2;
                default:             width = 4;
            endcase

            if (it.dest_size == x86enc_pkg::SZ_NONE)
            begin
                enc.push_back(x86enc_pkg::BYTE_BAD);
                st = x86enc_pkg::ST_NOT_REG;
            end
            else if (it.src_size != x86enc_pkg::SZ_NONE && it.src_size != it.dest_size)
            begin
                enc.push_back(x86enc_pkg::BYTE_BAD);
                st = x86enc_pkg::ST_MISMATCH;
            end
            else
            begin
                if (it.dest_size == x86enc_pkg::SZ_WORD)
                    enc.push_back(x86enc_pkg::BYTE_OPSIZE);
                if (it.src_size != x86enc_pkg::SZ_NONE)
                begin
                    enc.push_back(base + ((it.dest_size == x86enc_pkg::SZ_BYTE) ? 8'd0 : 8'd1));
                    enc.push_back(x86enc_pkg::BYTE_MODRM_REG
                                  | {2'b00, it.src_reg, it.dest_reg});
                end
                else if (it.op == x86enc_pkg::OP_MOV)
                begin
                    enc.push_back(((it.dest_size == x86enc_pkg::SZ_BYTE)
                                   ? x86enc_pkg::BYTE_MOV_IMM8 : x86enc_pkg::BYTE_MOV_IMM)
                                  + {5'b00000, it.dest_reg});
                    imm_len = width;
                end
                else if (it.dest_size == x86enc_pkg::SZ_BYTE)
                begin
                    if (it.dest_reg == x86enc_pkg::REG_ACC)
                        enc.push_back(base + 8'd4);
                    else
                    begin
                        enc.push_back(x86enc_pkg::BYTE_GRP1_IB);
                        enc.push_back(modrm_digit);
                    end
                    imm_len = 1;
                end
                else if (it.immediate < 32'd128)
                begin
                    enc.push_back(x86enc_pkg::BYTE_GRP1_SIB);
                    enc.push_back(modrm_digit);
                    imm_len = 1;
                end
                else
                begin
                    if (it.dest_reg == x86enc_pkg::REG_ACC)
                        enc.push_back(base + 8'd5);
                    else
                    begin
                        enc.push_back(x86enc_pkg::BYTE_GRP1_IZ);
                        enc.push_back(modrm_digit);
                    end
                    imm_len = width;
                end
                for (int i = 0; i < imm_len; i++)
                    enc.push_back(it.immediate[8*i +: 8]);
            end
        end
        else if (it.op == x86enc_pkg::OP_INT)
        begin
            enc.push_back(x86enc_pkg::BYTE_INT);
            enc.push_back(it.immediate[7:0]);
        end
        else
        begin
            case (it.op)
                x86enc_pkg::OP_HLT: one_byte = x86enc_pkg::BYTE_HLT;
                x86enc_pkg::OP_CLC: one_byte = x86enc_pkg::BYTE_CLC;
                x86enc_pkg::OP_CMC: one_byte = x86enc_pkg::BYTE_CMC;
                x86enc_pkg::OP_CLI: one_byte = x86enc_pkg::BYTE_CLI;
                x86enc_pkg::OP_CLD: one_byte = x86enc_pkg::BYTE_CLD;
                x86enc_pkg::OP_NOP: one_byte = x86enc_pkg::BYTE_NOP;
                default:            one_byte = x86enc_pkg::BYTE_BAD;
            endcase
            enc.push_back(one_byte);
        end

        for (int k = 0; k < enc.size(); k++)
        begin
            entry.code_byte = enc[k];
            entry.last_byte = (k == enc.size() - 1);
            entry.status    = st;
            expected_bytes.push_back(entry);
        end
    endfunction

    initial
    begin
        mismatch_count = 0;
        outstanding    = 0;
    end

    // Compare first, then predict: a byte never belongs to an instruction taken
    // at the same edge.
    always @(posedge clk)
    begin
        x86enc_pkg::code_t want;
        if (rst_n)
        begin
            if (code_valid && !code_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("code byte %0h with no instruction pending", code.code_byte);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (code.code_byte !== want.code_byte)
                    begin
                        $error("code_byte: expected %0h, actual %0h",
                               want.code_byte, code.code_byte);
                        mismatch_count++;
                    end
                    if (code.last_byte !== want.last_byte)
                    begin
                        $error("last_byte: expected %0b, actual %0b",
                               want.last_byte, code.last_byte);
                        mismatch_count++;
                    end
                    if (code.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, code.status);
                        mismatch_count++;
                    end
                end
            end
            if (item_valid && !item_stall)
                predict_encoding(item);
        end
        outstanding = expected_bytes.size();
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

    // Quiet cycles tolerated before the run is declared hung. The longest
    // legal quiet span is a sender gap plus a stall burst plus the pipeline
    // delay, so this leaves a wide margin.
    localparam int QUIET_LIMIT = 1000;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    x86enc_pkg::item_t item;
    logic              code_valid;
    logic              code_stall;
    x86enc_pkg::code_t code;

    int    mismatch_count;
    int    outstanding;

    // Odds (one in N) of an idle burst; zero turns idling off.
    int    gap_odds;
    int    stall_odds;

    x86_instruction_encoder u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code       (code)
    );

    encoding_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .code_valid     (code_valid),
        .code_stall     (code_stall),
        .code           (code),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive stall in random bursts; the odds come from the stimulus phase so
    // some stretches see no back-pressure at all.
    initial
    begin
        code_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                code_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                code_stall <= 1'b0;
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a transaction.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (code_valid && !code_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("x86_instruction_encoder regression: fail");
        $finish;
    end

    function automatic x86enc_pkg::item_t make_item(input logic [3:0] op,
                                                    input logic [1:0] dsz,
                                                    input logic [2:0] drg,
                                                    input logic [1:0] ssz,
                                                    input logic [2:0] srg,
                                                    input logic [31:0] imm);
        x86enc_pkg::item_t it;
        it.op        = op;
        it.dest_size = dsz;
        it.dest_reg  = drg;
        it.src_size  = ssz;
        it.src_reg   = srg;
        it.immediate = imm;
        return it;
    endfunction

    // Mostly well-formed ALU instructions with random content, some of the
    // other ops, and some fully random fields that hit the error paths.
    function automatic x86enc_pkg::item_t random_item();
        x86enc_pkg::item_t it;
        int                pick;
        it.op        = 4'($urandom);
        it.dest_size = 2'($urandom);
        it.dest_reg  = 3'($urandom);
        it.src_size  = 2'($urandom);
        it.src_reg   = 3'($urandom);
        it.immediate = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            it.op        = 4'($urandom_range(x86enc_pkg::OP_MOV, x86enc_pkg::OP_XOR));
            it.dest_size = 2'($urandom_range(x86enc_pkg::SZ_BYTE, x86enc_pkg::SZ_DWORD));
            it.src_size  = $urandom_range(0, 1) ? x86enc_pkg::SZ_NONE : it.dest_size;
            // keep the short-immediate boundary busy
            case ($urandom_range(0, 3))
                0: it.immediate = $urandom_range(0, 127);
                1: it.immediate = $urandom_range(120, 136);
                2: it.immediate = 32'hffff_ffff - $urandom_range(0, 3);
                default: it.immediate = $urandom;
            endcase
        end
        else if (pick < 85)
            it.op = 4'($urandom_range(x86enc_pkg::OP_INT, 15));
        return it;
    endfunction

    // Present one transaction and hold it until accepted. Valid stays high
    // into the next transaction unless an idle burst drops it first.
    task automatic send_item(input x86enc_pkg::item_t it);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall) @(posedge clk);
    endtask

    // Drop valid and hold off until every expected byte has been taken.
    task automatic drain_pipeline();
        item_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        gap_odds   = 0;
        stall_odds = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every operation, each encoding form and the error cases,
        // with light idling on both sides.
        gap_odds   = 4;
        stall_odds = 5;
        send_item(make_item(x86enc_pkg::OP_MOV, x86enc_pkg::SZ_BYTE, 3'd7,
                            x86enc_pkg::SZ_NONE, 3'd0, 32'hffff_ffff));
        send_item(make_item(x86enc_pkg::OP_MOV, x86enc_pkg::SZ_WORD, 3'd0,
                            x86enc_pkg::SZ_NONE, 3'd0, 32'h8000_1234));
        send_item(make_item(x86enc_pkg::OP_MOV, x86enc_pkg::SZ_DWORD, 3'd5,
                            x86enc_pkg::SZ_NONE, 3'd0, 32'hdead_beef));
        send_item(make_item(x86enc_pkg::OP_MOV, x86enc_pkg::SZ_DWORD, 3'd0,
                            x86enc_pkg::SZ_DWORD, 3'd7, 32'h0));
        send_item(make_item(x86enc_pkg::OP_ADD, x86enc_pkg::SZ_BYTE, 3'd0,
                            x86enc_pkg::SZ_NONE, 3'd0, 32'h0000_00ff));
        send_item(make_item(x86enc_pkg::OP_OR, x86enc_pkg::SZ_BYTE, 3'd6,
                            x86enc_pkg::SZ_NONE, 3'd0, 32'h1234_5680));
        send_item(make_item(x86enc_pkg::OP_SUB, x86enc_pkg::SZ_WORD, 3'd2,
                            x86enc_pkg::SZ_NONE, 3'd0, 32'd0));
        send_item(make_item(x86enc_pkg::OP_AND, x86enc_pkg::SZ_DWORD, 3'd1,
                            x86enc_pkg::SZ_NONE, 3'd0, 32'd127));
        send_item(make_item(x86enc_pkg::OP_XOR, x86enc_pkg::SZ_DWORD, 3'd0,
                            x86enc_pkg::SZ_NONE, 3'd0, 32'd128));
        send_item(make_item(x86enc_pkg::OP_ADD, x86enc_pkg::SZ_DWORD, 3'd3,
                            x86enc_pkg::SZ_NONE, 3'd0, 32'h8000_0000));
        send_item(make_item(x86enc_pkg::OP_SUB, x86enc_pkg::SZ_WORD, 3'd0,
                            x86enc_pkg::SZ_NONE, 3'd0, 32'h0001_ff80));
        send_item(make_item(x86enc_pkg::OP_AND, x86enc_pkg::SZ_WORD, 3'd4,
                            x86enc_pkg::SZ_WORD, 3'd5, 32'h0));
        send_item(make_item(x86enc_pkg::OP_OR, x86enc_pkg::SZ_BYTE, 3'd1,
                            x86enc_pkg::SZ_BYTE, 3'd2, 32'h0));
        send_item(make_item(x86enc_pkg::OP_XOR, x86enc_pkg::SZ_NONE, 3'd7,
                            x86enc_pkg::SZ_BYTE, 3'd7, 32'hffff_ffff));
        send_item(make_item(x86enc_pkg::OP_MOV, x86enc_pkg::SZ_DWORD, 3'd2,
                            x86enc_pkg::SZ_BYTE, 3'd3, 32'h0));
        send_item(make_item(x86enc_pkg::OP_INT, x86enc_pkg::SZ_NONE, 3'd0,
                            x86enc_pkg::SZ_NONE, 3'd0, 32'hffff_ff80));
        send_item(make_item(x86enc_pkg::OP_HLT, x86enc_pkg::SZ_DWORD, 3'd7,
                            x86enc_pkg::SZ_WORD, 3'd7, 32'hffff_ffff));
        send_item(make_item(x86enc_pkg::OP_CLC, x86enc_pkg::SZ_NONE, 3'd0,
                            x86enc_pkg::SZ_NONE, 3'd0, 32'h0));
        send_item(make_item(x86enc_pkg::OP_CMC, x86enc_pkg::SZ_NONE, 3'd0,
                            x86enc_pkg::SZ_NONE, 3'd0, 32'h0));
        send_item(make_item(x86enc_pkg::OP_CLI, x86enc_pkg::SZ_NONE, 3'd0,
                            x86enc_pkg::SZ_NONE, 3'd0, 32'h0));
        send_item(make_item(x86enc_pkg::OP_CLD, x86enc_pkg::SZ_NONE, 3'd0,
                            x86enc_pkg::SZ_NONE, 3'd0, 32'h0));
        send_item(make_item(x86enc_pkg::OP_NOP, x86enc_pkg::SZ_NONE, 3'd0,
                            x86enc_pkg::SZ_NONE, 3'd0, 32'h0));
        send_item(make_item(4'd13, x86enc_pkg::SZ_NONE, 3'd0,
                            x86enc_pkg::SZ_NONE, 3'd0, 32'h0));
        send_item(make_item(4'd15, x86enc_pkg::SZ_DWORD, 3'd7,
                            x86enc_pkg::SZ_DWORD, 3'd7, 32'hffff_ffff));

        // Random, first stretch: bursts of idling on both channels.
        gap_odds   = 3;
        stall_odds = 4;
        repeat (200) send_item(random_item());

        // Let the encoder run completely dry once before continuing.
        drain_pipeline();

        // Random, second stretch: sender back-to-back, receiver stalls often.
        gap_odds   = 0;
        stall_odds = 2;
        repeat (150) send_item(random_item());

        // Random, last stretch: no idling anywhere, full rate.
        stall_odds = 0;
        repeat (150) send_item(random_item());

        drain_pipeline();
        repeat (10) @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("x86_instruction_encoder regression: pass");
        else
            $display("x86_instruction_encoder regression: fail");
        $finish;
    end

endmodule

FILE: files.f
design/x86enc_pkg.sv
design/x86enc_encoder.sv
design/x86_instruction_encoder.sv
verif/encoding_checker.sv
verif/testbench.sv
